// File: design/xxh64_pkg.sv
// Shared types, constants and helpers for the XXH64 stream hasher.
package xxh64_pkg;

  localparam logic [63:0] PRIME_A = 64'd11400714785074694791;
  localparam logic [63:0] PRIME_B = 64'd14029467366897019727;
  localparam logic [63:0] PRIME_C = 64'd1609587929392839161;
  localparam logic [63:0] PRIME_D = 64'd9650029242287828579;
  localparam logic [63:0] PRIME_E = 64'd2870177450012600261;

  localparam int QUEUE_DEPTH = 2;

  // Input channel payload.
  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last_word;
  } xxh64_in_t;

  // Output channel payload.
  typedef struct packed {
    logic [63:0] hash_value;
  } xxh64_out_t;

  // One classified word as it travels from front to back.
  typedef struct packed {
    logic [63:0] word;   // masked to its valid bytes
    logic [3:0]  count;  // saturated byte count; 8 for words that are not last
    logic        last;
  } xxh64_item_t;

  // Each _A/_B/_C state runs one product on the shared multiplier.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RND_A,   // w*P2, add lane
    ST_RND_B,   // rotl 31, *P1
    ST_CONV,    // converge lanes or short start value
    ST_MRG_A,   // lane*P2
    ST_MRG_B,   // rotl 31, *P1
    ST_MRG_C,   // (h^v)*P1 + P4
    ST_WRD_A,
    ST_WRD_B,
    ST_WRD_C,
    ST_CHK_A,
    ST_CHK_B,
    ST_BYT_A,
    ST_BYT_B,
    ST_AVL_A,
    ST_AVL_B,
    ST_OUT
  } xxh64_state_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] r);
    logic [127:0] d;
    d = {v, v} << r;
    return d[127:64];
  endfunction

endpackage

// File: design/xxh64_stream_if.sv
// Valid/ready stream channel with a generic payload.
interface xxh64_stream_if #(
  parameter type payload_t = logic [63:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/xxh64_front.sv
// Front end: accepts words, classifies and masks them, and queues them.
module xxh64_front #(
  parameter int Depth = xxh64_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [63:0]           data_word,
  input  logic [3:0]            byte_count,
  input  logic                  last_word,
  output logic                  q_valid,
  input  logic                  q_ready,
  output xxh64_pkg::xxh64_item_t q_item
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  xxh64_pkg::xxh64_item_t slots [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   fill;
  logic          push;
  logic          pop;
  logic [3:0]    cnt_sat;
  logic [63:0]   mask;
  xxh64_pkg::xxh64_item_t item_in;

  always_comb begin
    cnt_sat = (byte_count > 4'd8) ? 4'd8 : byte_count;
    if (!last_word) cnt_sat = 4'd8;
    if (cnt_sat == 4'd0) mask = 64'd0;
    else mask = {64{1'b1}} >> (7'd64 - {cnt_sat[3:0], 3'b000});
    item_in.word  = data_word & mask;
    item_in.count = cnt_sat;
    item_in.last  = last_word;
  end

  assign in_ready = (fill != (AW+1)'(Depth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= item_in;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      fill <= fill + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (AW+1)'(Depth)) else $error("queue overfilled");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> !pop) else $error("pop from empty queue");
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (fill == (AW+1)'(Depth)) |-> !in_ready) else $error("ready while full");
endmodule

// File: design/xxh64_back.sv
// Back end: lane rounds on full stripes, finalization and avalanche.
module xxh64_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  xxh64_pkg::xxh64_item_t q_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [63:0]            hash_value
);
  xxh64_pkg::xxh64_state_t state, state_next;
  xxh64_pkg::xxh64_state_t tail_route;
  xxh64_pkg::xxh64_state_t fin_route;

  logic [63:0] lanes [4];
  logic [63:0] stripe [4];
  logic [1:0]  nbuf;
  logic [63:0] total;
  logic [63:0] h;
  logic [63:0] t;
  logic [63:0] tail;
  logic [3:0]  tcnt;
  logic [2:0]  bidx;
  logic [1:0]  idx;
  logic        last_q;
  logic        take;
  logic        issued;
  logic        mul_state;
  logic        mul_start;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic [63:0] ma_q;
  logic [63:0] mb_q;
  logic [63:0] macc;
  logic [1:0]  mstep;
  logic        mbusy;
  logic        mdone;
  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] mprod;

  assign q_ready    = (state == xxh64_pkg::ST_IDLE);
  assign take       = q_valid && q_ready;
  assign out_valid  = (state == xxh64_pkg::ST_OUT);
  assign hash_value = h;
  assign mul_start  = mul_state && !issued;

  // Low 64 bits of a 64x64 product from one 32x32 multiplier:
  // lo*lo, then the two cross terms shifted up by 32.
  always_comb begin
    case (mstep)
      2'd0: begin
        mx = ma_q[31:0];
        my = mb_q[31:0];
      end
      2'd1: begin
        mx = ma_q[31:0];
        my = mb_q[63:32];
      end
      default: begin
        mx = ma_q[63:32];
        my = mb_q[31:0];
      end
    endcase
    mprod = 64'(mx) * 64'(my);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mdone <= 1'b0;
      mstep <= '0;
    end else begin
      mdone <= 1'b0;
      if (mul_start) begin
        ma_q  <= mul_a;
        mb_q  <= mul_b;
        mstep <= '0;
        mbusy <= 1'b1;
      end else if (mbusy) begin
        case (mstep)
          2'd0:    macc <= mprod;
          default: macc <= macc + {mprod[31:0], 32'd0};
        endcase
        mstep <= mstep + 2'd1;
        if (mstep == 2'd2) begin
          mbusy <= 1'b0;
          mdone <= 1'b1;
        end
      end
    end
  end

  // Operand select for the state's product.
  always_comb begin
    mul_state = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      xxh64_pkg::ST_RND_A, xxh64_pkg::ST_WRD_A: begin
        mul_a = stripe[idx];
        mul_b = xxh64_pkg::PRIME_B;
      end
      xxh64_pkg::ST_RND_B, xxh64_pkg::ST_MRG_B, xxh64_pkg::ST_WRD_B: begin
        mul_a = xxh64_pkg::rotl64(t, 6'd31);
        mul_b = xxh64_pkg::PRIME_A;
      end
      xxh64_pkg::ST_MRG_A: begin
        mul_a = lanes[idx];
        mul_b = xxh64_pkg::PRIME_B;
      end
      xxh64_pkg::ST_MRG_C: begin
        mul_a = h ^ t;
        mul_b = xxh64_pkg::PRIME_A;
      end
      xxh64_pkg::ST_WRD_C: begin
        mul_a = xxh64_pkg::rotl64(h ^ t, 6'd27);
        mul_b = xxh64_pkg::PRIME_A;
      end
      xxh64_pkg::ST_CHK_A: begin
        mul_a = {32'd0, tail[31:0]};
        mul_b = xxh64_pkg::PRIME_A;
      end
      xxh64_pkg::ST_CHK_B: begin
        mul_a = xxh64_pkg::rotl64(h, 6'd23);
        mul_b = xxh64_pkg::PRIME_B;
      end
      xxh64_pkg::ST_BYT_A: begin
        mul_a = {56'd0, tail[{bidx, 3'b000} +: 8]};
        mul_b = xxh64_pkg::PRIME_E;
      end
      xxh64_pkg::ST_BYT_B: begin
        mul_a = xxh64_pkg::rotl64(h, 6'd11);
        mul_b = xxh64_pkg::PRIME_A;
      end
      xxh64_pkg::ST_AVL_A: begin
        mul_a = h ^ (h >> 33);
        mul_b = xxh64_pkg::PRIME_B;
      end
      xxh64_pkg::ST_AVL_B: begin
        mul_a = h ^ (h >> 29);
        mul_b = xxh64_pkg::PRIME_C;
      end
      default: mul_state = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= xxh64_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    if (tcnt >= 4'd4) tail_route = xxh64_pkg::ST_CHK_A;
    else if (tcnt != 4'd0) tail_route = xxh64_pkg::ST_BYT_A;
    else tail_route = xxh64_pkg::ST_AVL_A;
    fin_route = (nbuf != 2'd0) ? xxh64_pkg::ST_WRD_A : tail_route;
  end

  always_comb begin
    state_next = state;
    case (state)
      xxh64_pkg::ST_IDLE:
        if (take) begin
          if (q_item.count == 4'd8 && nbuf == 2'd3) state_next = xxh64_pkg::ST_RND_A;
          else if (q_item.last) state_next = xxh64_pkg::ST_CONV;
        end
      xxh64_pkg::ST_RND_A:
        if (mdone) state_next = xxh64_pkg::ST_RND_B;
      xxh64_pkg::ST_RND_B:
        if (mdone) begin
          if (idx != 2'd3) state_next = xxh64_pkg::ST_RND_A;
          else state_next = last_q ? xxh64_pkg::ST_CONV : xxh64_pkg::ST_IDLE;
        end
      xxh64_pkg::ST_CONV:
        state_next = (total >= 64'd32) ? xxh64_pkg::ST_MRG_A : fin_route;
      xxh64_pkg::ST_MRG_A:
        if (mdone) state_next = xxh64_pkg::ST_MRG_B;
      xxh64_pkg::ST_MRG_B:
        if (mdone) state_next = xxh64_pkg::ST_MRG_C;
      xxh64_pkg::ST_MRG_C:
        if (mdone) state_next = (idx != 2'd3) ? xxh64_pkg::ST_MRG_A : fin_route;
      xxh64_pkg::ST_WRD_A:
        if (mdone) state_next = xxh64_pkg::ST_WRD_B;
      xxh64_pkg::ST_WRD_B:
        if (mdone) state_next = xxh64_pkg::ST_WRD_C;
      xxh64_pkg::ST_WRD_C:
        if (mdone) state_next = (idx != nbuf - 2'd1) ? xxh64_pkg::ST_WRD_A : tail_route;
      xxh64_pkg::ST_CHK_A:
        if (mdone) state_next = xxh64_pkg::ST_CHK_B;
      xxh64_pkg::ST_CHK_B:
        if (mdone) state_next = (tcnt > 4'd4) ? xxh64_pkg::ST_BYT_A : xxh64_pkg::ST_AVL_A;
      xxh64_pkg::ST_BYT_A:
        if (mdone) state_next = xxh64_pkg::ST_BYT_B;
      xxh64_pkg::ST_BYT_B:
        if (mdone) begin
          if ({1'b0, bidx} + 4'd1 >= tcnt) state_next = xxh64_pkg::ST_AVL_A;
          else state_next = xxh64_pkg::ST_BYT_A;
        end
      xxh64_pkg::ST_AVL_A:
        if (mdone) state_next = xxh64_pkg::ST_AVL_B;
      xxh64_pkg::ST_AVL_B:
        if (mdone) state_next = xxh64_pkg::ST_OUT;
      xxh64_pkg::ST_OUT:
        if (out_ready) state_next = xxh64_pkg::ST_IDLE;
      default: state_next = xxh64_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lanes[0] <= xxh64_pkg::PRIME_A + xxh64_pkg::PRIME_B;
      lanes[1] <= xxh64_pkg::PRIME_B;
      lanes[2] <= 64'd0;
      lanes[3] <= 64'd0 - xxh64_pkg::PRIME_A;
      nbuf <= '0; total <= '0; idx <= '0; bidx <= '0;
      tcnt <= '0; last_q <= 1'b0; issued <= 1'b0;
    end else begin
      if (mul_start) issued <= 1'b1;
      else if (mdone) issued <= 1'b0;
      case (state)
        xxh64_pkg::ST_IDLE:
          if (take) begin
            idx    <= '0;
            bidx   <= '0;
            last_q <= q_item.last;
            total  <= total + {60'd0, q_item.count};
            tail   <= q_item.word;
            if (q_item.count == 4'd8) begin
              stripe[nbuf] <= q_item.word;
              nbuf <= nbuf + 2'd1;
              tcnt <= 4'd0;
            end else tcnt <= q_item.count;
          end
        xxh64_pkg::ST_RND_A:
          if (mdone) t <= lanes[idx] + macc;
        xxh64_pkg::ST_RND_B:
          if (mdone) begin
            lanes[idx] <= macc;
            idx <= idx + 2'd1;
          end
        xxh64_pkg::ST_CONV: begin
          idx <= '0;
          if (total >= 64'd32)
            h <= xxh64_pkg::rotl64(lanes[0], 6'd1) + xxh64_pkg::rotl64(lanes[1], 6'd7)
               + xxh64_pkg::rotl64(lanes[2], 6'd12) + xxh64_pkg::rotl64(lanes[3], 6'd18);
          else h <= lanes[2] + xxh64_pkg::PRIME_E + total;
        end
        xxh64_pkg::ST_MRG_A, xxh64_pkg::ST_MRG_B, xxh64_pkg::ST_WRD_A, xxh64_pkg::ST_WRD_B:
          if (mdone) t <= macc;
        xxh64_pkg::ST_MRG_C:
          if (mdone) begin
            // length goes in after the last merge
            h <= macc + xxh64_pkg::PRIME_D + ((idx == 2'd3) ? total : 64'd0);
            idx <= idx + 2'd1;
          end
        xxh64_pkg::ST_WRD_C:
          if (mdone) begin
            h <= macc + xxh64_pkg::PRIME_D;
            idx <= idx + 2'd1;
          end
        xxh64_pkg::ST_CHK_A, xxh64_pkg::ST_BYT_A:
          if (mdone) h <= h ^ macc;
        xxh64_pkg::ST_CHK_B:
          if (mdone) begin
            h <= macc + xxh64_pkg::PRIME_C;
            bidx <= 3'd4;
          end
        xxh64_pkg::ST_BYT_B:
          if (mdone) begin
            h <= macc;
            bidx <= bidx + 3'd1;
          end
        xxh64_pkg::ST_AVL_A:
          if (mdone) h <= macc;
        xxh64_pkg::ST_AVL_B:
          if (mdone) h <= macc ^ (macc >> 32);
        xxh64_pkg::ST_OUT:
          if (out_ready) begin
            lanes[0] <= xxh64_pkg::PRIME_A + xxh64_pkg::PRIME_B;
            lanes[1] <= xxh64_pkg::PRIME_B;
            lanes[2] <= 64'd0;
            lanes[3] <= 64'd0 - xxh64_pkg::PRIME_A;
            nbuf <= '0; total <= '0;
          end
        default: ;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hash_value)) else $error("result dropped");
  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    (state != xxh64_pkg::ST_IDLE) |-> !q_ready) else $error("take while busy");
  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mbusy) else $error("multiplier started while busy");
  a_done_owned: assert property (@(posedge clk) disable iff (rst)
    mdone |-> issued) else $error("product with no request");
endmodule

// File: design/xxhash64_stream_hasher_core.sv
// XXH64 (seed 0) stream hasher. Words enter a QueueDepth-entry queue that takes one transfer
// a cycle while it has room; the back end takes an ordinary word in its idle state and stays
// idle, ready for the next. All multiplies share one 32x32 multiplier that builds each 64-bit
// product from partial products, so a word that completes a 32-byte stripe holds the back end
// for two products per lane, and a last word passes through take, converge, lane merge
// (messages of 32 bytes or more), a round per buffered word, the 4-byte chunk, each single
// tail byte and avalanche, after the stripe rounds if it completes a stripe, before the hash
// shows; the hash is held until taken and the next word is taken the cycle after.
module xxhash64_stream_hasher_core #(
  parameter int QueueDepth = xxh64_pkg::QUEUE_DEPTH
) (
  input logic clk,
  input logic rst,
  xxh64_stream_if.sink   in_ch,
  xxh64_stream_if.source out_ch
);
  logic                   q_valid;
  logic                   q_ready;
  xxh64_pkg::xxh64_item_t q_item;

  xxh64_front #(.Depth(QueueDepth)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .data_word(in_ch.payload.data_word),
    .byte_count(in_ch.payload.byte_count),
    .last_word(in_ch.payload.last_word),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  xxh64_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .hash_value(out_ch.payload.hash_value)
  );
endmodule

// File: dv/tb_xxhash64_stream_hasher_core.sv
// Testbench for the XXH64 stream hasher: directed and random messages checked against a predictor.
module tb_xxhash64_stream_hasher_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;

  xxh64_stream_if #(.payload_t(xxh64_pkg::xxh64_in_t)) word_if ();
  xxh64_stream_if #(.payload_t(xxh64_pkg::xxh64_out_t)) hash_if ();

  xxhash64_stream_hasher_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (word_if.sink),
    .out_ch (hash_if.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // digest predictor state
  logic [63:0] lane_acc [4];
  logic [63:0] stripe_words [4];
  int unsigned stripe_fill;
  logic [63:0] msg_bytes;

  logic [63:0] hash_queue [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit stall_enable = 1'b1;

  function automatic logic [63:0] rol64(input logic [63:0] v, input int unsigned r);
    return (r == 0) ? v : ((v << r) | (v >> (64 - r)));
  endfunction

  function automatic logic [63:0] lane_mix(input logic [63:0] acc, input logic [63:0] w);
    logic [63:0] t;
    t = acc + w * xxh64_pkg::PRIME_B;
    t = rol64(t, 31);
    return t * xxh64_pkg::PRIME_A;
  endfunction

  function automatic logic [63:0] final_mix(input logic [63:0] h0);
    logic [63:0] h;
    h = h0;
    h = h ^ (h >> 33);
    h = h * xxh64_pkg::PRIME_B;
    h = h ^ (h >> 29);
    h = h * xxh64_pkg::PRIME_C;
    h = h ^ (h >> 32);
    return h;
  endfunction

  task automatic clear_digest();
    lane_acc[0] = xxh64_pkg::PRIME_A + xxh64_pkg::PRIME_B;
    lane_acc[1] = xxh64_pkg::PRIME_B;
    lane_acc[2] = 64'd0;
    lane_acc[3] = 64'd0 - xxh64_pkg::PRIME_A;
    for (int i = 0; i < 4; i++) stripe_words[i] = 64'd0;
    stripe_fill = 0;
    msg_bytes = 64'd0;
  endtask

  task automatic absorb_word(input logic [63:0] w);
    stripe_words[stripe_fill] = w;
    stripe_fill++;
    if (stripe_fill == 4) begin
      for (int i = 0; i < 4; i++) lane_acc[i] = lane_mix(lane_acc[i], stripe_words[i]);
      stripe_fill = 0;
    end
  endtask

  function automatic logic [63:0] close_digest(input logic [63:0] tail, input int unsigned nb);
    logic [63:0] h;
    int unsigned k;
    if (msg_bytes >= 64'd32) begin
      h = rol64(lane_acc[0], 1) + rol64(lane_acc[1], 7) + rol64(lane_acc[2], 12)
        + rol64(lane_acc[3], 18);
      for (int i = 0; i < 4; i++) begin
        h = h ^ lane_mix(64'd0, lane_acc[i]);
        h = h * xxh64_pkg::PRIME_A + xxh64_pkg::PRIME_D;
      end
    end else begin
      h = lane_acc[2] + xxh64_pkg::PRIME_E;
    end
    h = h + msg_bytes;
    for (int i = 0; i < stripe_fill; i++) begin
      h = h ^ lane_mix(64'd0, stripe_words[i]);
      h = rol64(h, 27) * xxh64_pkg::PRIME_A + xxh64_pkg::PRIME_D;
    end
    k = 0;
    if (nb >= 4) begin
      h = h ^ ({32'd0, tail[31:0]} * xxh64_pkg::PRIME_A);
      h = rol64(h, 23) * xxh64_pkg::PRIME_B + xxh64_pkg::PRIME_C;
      k = 4;
    end
    for (; k < nb; k++) begin
      h = h ^ ({56'd0, tail[8*k +: 8]} * xxh64_pkg::PRIME_E);
      h = rol64(h, 11) * xxh64_pkg::PRIME_A;
    end
    return final_mix(h);
  endfunction

  task automatic predict_word(input logic [63:0] w, input logic [3:0] cnt, input logic lst);
    int unsigned nb;
    logic [63:0] tail;
    nb = (cnt > 4'd8) ? 8 : cnt;
    if (!lst) begin
      msg_bytes = msg_bytes + 64'd8;
      absorb_word(w);
    end else begin
      msg_bytes = msg_bytes + nb;
      if (nb == 8) begin
        absorb_word(w);
        hash_queue.push_back(close_digest(64'd0, 0));
      end else begin
        tail = (nb == 0) ? 64'd0 : (w & ({64{1'b1}} >> (64 - 8 * nb)));
        hash_queue.push_back(close_digest(tail, nb));
      end
      clear_digest();
    end
  endtask

  task automatic send_word(input logic [63:0] w, input logic [3:0] cnt, input logic lst);
    if (stall_enable && $urandom_range(99) < 19) begin
      word_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 19);
    end
    word_if.valid   <= 1'b1;
    word_if.payload <= '{data_word: w, byte_count: cnt, last_word: lst};
    do @(posedge clk); while (!word_if.ready);
    predict_word(w, cnt, lst);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // body words carry a random count, which must be ignored
  task automatic send_message(input int unsigned body_words, input logic [3:0] last_cnt);
    for (int i = 0; i < body_words; i++) send_word(rand64(), 4'($urandom_range(15)), 1'b0);
    send_word(rand64(), last_cnt, 1'b1);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      hash_if.ready <= 1'b0;
    end else begin
      if (hash_if.valid && hash_if.ready) begin
        if (hash_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected hash transfer %h", hash_if.payload.hash_value);
        end else begin
          logic [63:0] want;
          want = hash_queue.pop_front();
          if (hash_if.payload.hash_value !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("hash mismatch: expected %h actual %h", want,
                       hash_if.payload.hash_value);
          end
        end
      end
      hash_if.ready <= !(stall_enable && $urandom_range(99) < 19);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_short_messages();
    send_word(64'd0, 4'd0, 1'b1);                       // empty message
    send_word(rand64(), 4'd4, 1'b1);                    // chunk only
    send_word(rand64(), 4'd7, 1'b1);                    // chunk plus bytes
    send_word({64{1'b1}}, 4'd3, 1'b1);                  // high bytes masked off
    send_word({64{1'b1}}, 4'd12, 1'b1);                 // count saturates at eight
  endtask

  task automatic test_buffered_tail();
    send_word(64'd0, 4'd3, 1'b0);                       // short count, not last
    send_word({64{1'b1}}, 4'd15, 1'b0);
    send_word(rand64(), 4'd0, 1'b0);
    send_word(rand64(), 4'd5, 1'b1);
  endtask

  task automatic test_stripe_edges();
    send_message(3, 4'd8);                              // exactly 32 bytes
    for (int i = 0; i < 4; i++) send_word({64{1'b1}}, 4'd8, 1'b0);
    send_word({64{1'b1}}, 4'd8, 1'b1);                  // full stripe then buffered word
    send_message(4, 4'd0);                              // stripe then empty last
    send_message(0, 4'd15);
  endtask

  task automatic test_random_messages();
    int unsigned sent;
    int unsigned body;
    sent = 0;
    while (sent < 1650) begin
      stall_enable = !(sent >= 600 && sent < 900);
      if ($urandom_range(9) == 0) body = $urandom_range(40, 16);
      else body = $urandom_range(10);
      send_message(body, 4'($urandom_range(15)));
      sent += body + 1;
    end
    stall_enable = 1'b1;
  endtask

  initial begin
    word_if.valid   = 1'b0;
    word_if.payload = '0;
    clear_digest();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_messages();
    test_buffered_tail();
    test_stripe_edges();
    test_random_messages();
    word_if.valid <= 1'b0;
    while (hash_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
